// File: design/fk6_pkg.sv
// Shared types, constants and arithmetic helpers for the arm kinematics pipeline.
`default_nettype none
package fk6_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int LANES        = 6;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [33:0]   op_t;
  typedef logic signed [35:0]   wide_t;
  typedef logic signed [31:0]   trig_t;

  localparam cw_t Q_ONE       = 34'sd1073741824;
  localparam cw_t HALF_TURN   = 34'sd2147483648;
  localparam cw_t CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // register indexes on the config port
  localparam logic [2:0] CFG_BASE_HEIGHT = 3'd0;
  localparam logic [2:0] CFG_UPPER_ARM   = 3'd1;
  localparam logic [2:0] CFG_FOREARM     = 3'd2;
  localparam logic [2:0] CFG_HAND        = 3'd3;
  localparam logic [2:0] CFG_REACH_SQ    = 3'd4;
  localparam logic [2:0] CFG_EPS_ABOVE   = 3'd5;
  localparam logic [2:0] CFG_EPS_EXT     = 3'd6;
  localparam logic [2:0] CFG_EPS_PAR     = 3'd7;

  typedef struct packed {
    logic signed [15:0] joint1_angle;
    logic signed [15:0] joint2_angle;
    logic signed [15:0] joint3_angle;
    logic signed [15:0] joint4_angle;
    logic signed [15:0] joint5_angle;
    logic signed [15:0] joint6_angle;
  } fk_in_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] rot_col0;
    logic signed [31:0] rot_col1;
    logic signed [31:0] rot_col2;
    logic signed [31:0] tool_position;
    logic signed [31:0] wrist_position;
    logic signed [31:0] wrist_vertical;
    logic signed [31:0] wrist_horizontal;
    logic [6:0]         status_bits;
    logic               singular;
    logic               last;
  } fk_out_t;

  // exact product, floor shift back to the fraction
  function automatic wide_t fmul(input op_t a, input op_t b);
    logic signed [67:0] p;
    p = a * b;
    return wide_t'(p >>> FRAC_BITS);
  endfunction

  function automatic op_t op_trig(input trig_t v);
    return op_t'(v);
  endfunction

  function automatic op_t op_wide(input wide_t v);
    return op_t'(v);
  endfunction

  function automatic op_t op_len(input logic [30:0] v);
    return op_t'({3'b000, v});
  endfunction

  function automatic cw_t clamp_one(input cw_t v);
    cw_t r;
    if (v > Q_ONE) r = Q_ONE;
    else if (v < -Q_ONE) r = -Q_ONE;
    else r = v;
    return r;
  endfunction

  function automatic trig_t clamp_rot(input wide_t v);
    wide_t hi;
    trig_t r;
    hi = wide_t'(1) <<< FRAC_BITS;
    if (v > hi) r = trig_t'(hi);
    else if (v < -hi) r = trig_t'(-hi);
    else r = trig_t'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/six_joint_arm_forward_kinematics.sv
// Top level: pipelined forward kinematics of a six-joint arm, three row words per item.
// An accepted item passes the CORDIC lanes, stages F and M1 to M5 and the row
// serializer; rows x, y, z then strobe back to back. A new item is taken only while
// busy is low; busy follows each accept so that the single output port carrying
// three rows is not overrun. Six 30-step CORDIC lanes and the product stages are fully
// pipelined. Synchronous active-low reset clears valid bits, counters and config registers.
`default_nettype none
module six_joint_arm_forward_kinematics (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire fk6_pkg::fk_in_t in_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [62:0]     cfg_data,
  output logic                 out_valid,
  output fk6_pkg::fk_out_t     out_data
);
  import fk6_pkg::*;

  // ---------------- configuration ----------------
  logic [30:0] base_r, upper_r, fore_r, hand_r, eps_above_r, eps_ext_r, eps_par_r;
  logic [62:0] reach_r;
  logic [61:0] eps_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; upper_r <= '0; fore_r <= '0; hand_r <= '0;
      reach_r <= '0; eps_above_r <= '0; eps_ext_r <= '0; eps_par_r <= '0;
      eps_sq_r <= '0;
    end else begin
      eps_sq_r <= eps_ext_r * eps_ext_r;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_HEIGHT: base_r      <= cfg_data[30:0];
          CFG_UPPER_ARM:   upper_r     <= cfg_data[30:0];
          CFG_FOREARM:     fore_r      <= cfg_data[30:0];
          CFG_HAND:        hand_r      <= cfg_data[30:0];
          CFG_REACH_SQ:    reach_r     <= cfg_data;
          CFG_EPS_ABOVE:   eps_above_r <= cfg_data[30:0];
          CFG_EPS_EXT:     eps_ext_r   <= cfg_data[30:0];
          CFG_EPS_PAR:     eps_par_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- input handshake ----------------
  logic       accept;
  logic [1:0] acc_hist_r;

  assign accept = start && !busy;
  assign busy   = |acc_hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) acc_hist_r <= '0;
    else acc_hist_r <= {acc_hist_r[0], accept};
  end

  // ---------------- angle prep ----------------
  logic [31:0] ang [0:LANES-1];
  cw_t         z_in [0:LANES-1];
  logic        neg_in [0:LANES-1];

  function automatic logic [31:0] to_ang32(input logic [15:0] v);
    logic [31:0] e;
    e = {16'b0, v};
    return {e[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  endfunction

  always_comb begin
    ang[0] = to_ang32(in_data.joint1_angle);
    ang[1] = to_ang32(in_data.joint2_angle);
    ang[2] = to_ang32(in_data.joint2_angle) + to_ang32(in_data.joint3_angle);
    ang[3] = to_ang32(in_data.joint4_angle);
    ang[4] = to_ang32(in_data.joint5_angle);
    ang[5] = to_ang32(in_data.joint6_angle);
    for (int k = 0; k < LANES; k++) begin
      z_in[k]   = cw_t'(signed'(ang[k]));
      neg_in[k] = 1'b0;
      // fold into the half plane the iteration converges on
      if (z_in[k] > Q_ONE) begin
        z_in[k]   = z_in[k] - HALF_TURN;
        neg_in[k] = 1'b1;
      end else if (z_in[k] < -Q_ONE) begin
        z_in[k]   = z_in[k] + HALF_TURN;
        neg_in[k] = 1'b1;
      end
    end
  end

  // ---------------- CORDIC lanes ----------------
  cw_t        cx_r   [0:CORDIC_STEPS][0:LANES-1];
  cw_t        cy_r   [0:CORDIC_STEPS][0:LANES-1];
  cw_t        cz_r   [0:CORDIC_STEPS][0:LANES-1];
  logic       cneg_r [0:CORDIC_STEPS][0:LANES-1];
  logic       cv_r   [0:CORDIC_STEPS];
  logic [1:0] cflag_r[0:CORDIC_STEPS];  // {elbow down, flip}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) cv_r[i] <= 1'b0;
    end else begin
      cv_r[0] <= accept;
      for (int i = 0; i < CORDIC_STEPS; i++) cv_r[i+1] <= cv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    cflag_r[0] <= {in_data.joint3_angle[ANGLE_BITS-1], in_data.joint5_angle[ANGLE_BITS-1]};
    for (int i = 0; i < CORDIC_STEPS; i++) cflag_r[i+1] <= cflag_r[i];
    for (int k = 0; k < LANES; k++) begin
      cx_r[0][k]   <= CORDIC_GAIN;
      cy_r[0][k]   <= '0;
      cz_r[0][k]   <= z_in[k];
      cneg_r[0][k] <= neg_in[k];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    for (genvar k = 0; k < LANES; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (!cz_r[i][k][CW-1]) begin
          cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
          cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
          cz_r[i+1][k] <= cz_r[i][k] - cw_t'({2'b00, ATAN_TAB[i]});
        end else begin
          cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
          cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
          cz_r[i+1][k] <= cz_r[i][k] + cw_t'({2'b00, ATAN_TAB[i]});
        end
        cneg_r[i+1][k] <= cneg_r[i][k];
      end
    end
  end

  // ---------------- F: sign fix, clamp, scale ----------------
  trig_t      tc_r [0:LANES-1];
  trig_t      ts_r [0:LANES-1];
  trig_t      s5raw_r;
  logic       f_v_r;
  logic [1:0] f_flag_r;
  cw_t        xc_c [0:LANES-1];
  cw_t        yc_c [0:LANES-1];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      xc_c[k] = clamp_one(cneg_r[CORDIC_STEPS][k] ? -cx_r[CORDIC_STEPS][k]
                                                 :  cx_r[CORDIC_STEPS][k]);
      yc_c[k] = clamp_one(cneg_r[CORDIC_STEPS][k] ? -cy_r[CORDIC_STEPS][k]
                                                 :  cy_r[CORDIC_STEPS][k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      tc_r[k] <= trig_t'(xc_c[k] >>> (30 - FRAC_BITS));
      ts_r[k] <= trig_t'(yc_c[k] >>> (30 - FRAC_BITS));
    end
    s5raw_r  <= trig_t'(yc_c[4]);
    f_flag_r <= cflag_r[CORDIC_STEPS];
  end

  // ---------------- M1: first products ----------------
  wide_t m1_s5c6_r, m1_s5s6_r, m1_c4s5_r, m1_s4s5_r, m1_c1c23_r, m1_c1s23_r;
  wide_t m1_s1c23_r, m1_s1s23_r, m1_s4c5_r, m1_c4c5_r, m1_c4c6_r, m1_s4c6_r;
  wide_t m1_s4s6_r, m1_c4s6_r, m1_c2l1_r, m1_s2l1_r, m1_c23l2_r, m1_s23l2_r;
  trig_t m1_c1_r, m1_s1_r, m1_c23_r, m1_s23_r, m1_c5_r, m1_c6_r, m1_s6_r;
  logic  m1_v_r, m1_par_r;
  logic [1:0]  m1_flag_r;
  logic [32:0] s5_mag;

  assign s5_mag = s5raw_r[31] ? 33'(-(33'(s5raw_r))) : 33'(s5raw_r);

  always_ff @(posedge clk) begin
    m1_s5c6_r  <= fmul(op_trig(ts_r[4]), op_trig(tc_r[5]));
    m1_s5s6_r  <= fmul(op_trig(ts_r[4]), op_trig(ts_r[5]));
    m1_c4s5_r  <= fmul(op_trig(tc_r[3]), op_trig(ts_r[4]));
    m1_s4s5_r  <= fmul(op_trig(ts_r[3]), op_trig(ts_r[4]));
    m1_c1c23_r <= fmul(op_trig(tc_r[0]), op_trig(tc_r[2]));
    m1_c1s23_r <= fmul(op_trig(tc_r[0]), op_trig(ts_r[2]));
    m1_s1c23_r <= fmul(op_trig(ts_r[0]), op_trig(tc_r[2]));
    m1_s1s23_r <= fmul(op_trig(ts_r[0]), op_trig(ts_r[2]));
    m1_s4c5_r  <= fmul(op_trig(ts_r[3]), op_trig(tc_r[4]));
    m1_c4c5_r  <= fmul(op_trig(tc_r[3]), op_trig(tc_r[4]));
    m1_c4c6_r  <= fmul(op_trig(tc_r[3]), op_trig(tc_r[5]));
    m1_s4c6_r  <= fmul(op_trig(ts_r[3]), op_trig(tc_r[5]));
    m1_s4s6_r  <= fmul(op_trig(ts_r[3]), op_trig(ts_r[5]));
    m1_c4s6_r  <= fmul(op_trig(tc_r[3]), op_trig(ts_r[5]));
    m1_c2l1_r  <= fmul(op_trig(tc_r[1]), op_len(upper_r));
    m1_s2l1_r  <= fmul(op_trig(ts_r[1]), op_len(upper_r));
    m1_c23l2_r <= fmul(op_trig(tc_r[2]), op_len(fore_r));
    m1_s23l2_r <= fmul(op_trig(ts_r[2]), op_len(fore_r));
    m1_c1_r  <= tc_r[0];
    m1_s1_r  <= ts_r[0];
    m1_c23_r <= tc_r[2];
    m1_s23_r <= ts_r[2];
    m1_c5_r  <= tc_r[4];
    m1_c6_r  <= tc_r[5];
    m1_s6_r  <= ts_r[5];
    m1_par_r <= s5_mag < {2'b00, eps_par_r};
    m1_flag_r <= f_flag_r;
  end

  // ---------------- M2: wrist terms, arm distances ----------------
  wide_t m2_m1a_r, m2_m2a_r, m2_m1b_r, m2_m2b_r, m2_dwv_r, m2_dwh_r;
  wide_t m2_s5s6_r, m2_s5c6_r, m2_c4s5_r, m2_s4s5_r;
  wide_t m2_c1c23_r, m2_c1s23_r, m2_s1c23_r, m2_s1s23_r;
  trig_t m2_c1_r, m2_s1_r, m2_c23_r, m2_s23_r, m2_c5_r;
  logic  m2_v_r, m2_par_r;
  logic [1:0] m2_flag_r;

  always_ff @(posedge clk) begin
    m2_m1a_r <= fmul(op_wide(m1_s4c5_r), op_trig(m1_s6_r)) - m1_c4c6_r;
    m2_m2a_r <= fmul(op_wide(m1_c4c5_r), op_trig(m1_s6_r)) + m1_s4c6_r;
    m2_m1b_r <= fmul(op_wide(m1_s4c5_r), op_trig(m1_c6_r)) + m1_c4s6_r;
    m2_m2b_r <= fmul(op_wide(m1_c4c5_r), op_trig(m1_c6_r)) - m1_s4s6_r;
    m2_dwv_r <= m1_c2l1_r + m1_c23l2_r;
    m2_dwh_r <= m1_s2l1_r + m1_s23l2_r;
    m2_s5s6_r <= m1_s5s6_r;   m2_s5c6_r <= m1_s5c6_r;
    m2_c4s5_r <= m1_c4s5_r;   m2_s4s5_r <= m1_s4s5_r;
    m2_c1c23_r <= m1_c1c23_r; m2_c1s23_r <= m1_c1s23_r;
    m2_s1c23_r <= m1_s1c23_r; m2_s1s23_r <= m1_s1s23_r;
    m2_c1_r <= m1_c1_r; m2_s1_r <= m1_s1_r;
    m2_c23_r <= m1_c23_r; m2_s23_r <= m1_s23_r; m2_c5_r <= m1_c5_r;
    m2_par_r <= m1_par_r;
    m2_flag_r <= m1_flag_r;
  end

  // ---------------- M3: matrix terms, wrist products, squares ----------------
  wide_t pa_r [0:2][0:2];
  wide_t pb_r [0:1][0:2];
  wide_t pc_r [0:2][0:2];   // column 2 holds the negated term
  wide_t m3_pws_r, m3_pwc_r, m3_dwv_r, m3_dwh_r;
  logic [63:0] m3_sqv_r, m3_sqh_r;
  logic  m3_v_r, m3_par_r, m3_back_r, m3_above_r;
  logic [1:0] m3_flag_r;
  logic [35:0] dwv_mag, dwh_mag;

  assign dwv_mag = m2_dwv_r[35] ? 36'(-m2_dwv_r) : 36'(m2_dwv_r);
  assign dwh_mag = m2_dwh_r[35] ? 36'(-m2_dwh_r) : 36'(m2_dwh_r);

  always_ff @(posedge clk) begin
    pa_r[0][0] <= fmul(op_wide(m2_s1c23_r), op_wide(m2_m2a_r));
    pa_r[1][0] <= fmul(op_wide(m2_c1c23_r), op_wide(m2_m2a_r));
    pa_r[2][0] <= fmul(op_trig(m2_s23_r),   op_wide(m2_m2a_r));
    pb_r[0][0] <= fmul(op_trig(m2_c1_r),    op_wide(m2_m1a_r));
    pb_r[1][0] <= fmul(op_trig(m2_s1_r),    op_wide(m2_m1a_r));
    pc_r[0][0] <= fmul(op_wide(m2_s1s23_r), op_wide(m2_s5s6_r));
    pc_r[1][0] <= fmul(op_wide(m2_c1s23_r), op_wide(m2_s5s6_r));
    pc_r[2][0] <= fmul(op_trig(m2_c23_r),   op_wide(m2_s5s6_r));

    pa_r[0][1] <= fmul(op_wide(m2_s1c23_r), op_wide(m2_m2b_r));
    pa_r[1][1] <= fmul(op_wide(m2_c1c23_r), op_wide(m2_m2b_r));
    pa_r[2][1] <= fmul(op_trig(m2_s23_r),   op_wide(m2_m2b_r));
    pb_r[0][1] <= fmul(op_trig(m2_c1_r),    op_wide(m2_m1b_r));
    pb_r[1][1] <= fmul(op_trig(m2_s1_r),    op_wide(m2_m1b_r));
    pc_r[0][1] <= fmul(op_wide(m2_s1s23_r), op_wide(m2_s5c6_r));
    pc_r[1][1] <= fmul(op_wide(m2_c1s23_r), op_wide(m2_s5c6_r));
    pc_r[2][1] <= fmul(op_trig(m2_c23_r),   op_wide(m2_s5c6_r));

    pa_r[0][2] <= fmul(op_wide(m2_s1c23_r), op_wide(m2_c4s5_r));
    pa_r[1][2] <= fmul(op_wide(m2_c1c23_r), op_wide(m2_c4s5_r));
    pa_r[2][2] <= fmul(op_trig(m2_s23_r),   op_wide(m2_c4s5_r));
    pb_r[0][2] <= fmul(op_trig(m2_c1_r),    op_wide(m2_s4s5_r));
    pb_r[1][2] <= fmul(op_trig(m2_s1_r),    op_wide(m2_s4s5_r));
    pc_r[0][2] <= -fmul(op_wide(m2_s1s23_r), op_trig(m2_c5_r));
    pc_r[1][2] <= -fmul(op_wide(m2_c1s23_r), op_trig(m2_c5_r));
    pc_r[2][2] <= -fmul(op_trig(m2_c23_r),   op_trig(m2_c5_r));

    m3_pws_r <= fmul(op_trig(m2_s1_r), op_wide(m2_dwh_r));
    m3_pwc_r <= fmul(op_trig(m2_c1_r), op_wide(m2_dwh_r));
    m3_dwv_r <= m2_dwv_r;
    m3_dwh_r <= m2_dwh_r;
    // distances stay below 2^32 in magnitude
    m3_sqv_r <= dwv_mag[31:0] * dwv_mag[31:0];
    m3_sqh_r <= dwh_mag[31:0] * dwh_mag[31:0];
    m3_back_r  <= m2_dwh_r[35];
    m3_above_r <= dwh_mag < {5'b0, eps_above_r};
    m3_par_r   <= m2_par_r;
    m3_flag_r  <= m2_flag_r;
  end

  // ---------------- M4: matrix sums, positions, reach ----------------
  trig_t rot_r [0:2][0:2];
  wide_t m4_pw_r [0:2];
  wide_t m4_dwv_r, m4_dwh_r;
  logic [63:0] m4_r2_r;
  logic  m4_v_r, m4_ext_r, m4_par_r, m4_back_r, m4_above_r;
  logic [1:0] m4_flag_r;
  logic [64:0] r2_sum;
  logic [63:0] r2_c, e2_c, reach_c;
  logic        ext_c;

  always_comb begin
    r2_sum  = {1'b0, m3_sqv_r} + {1'b0, m3_sqh_r};
    r2_c    = r2_sum[64] ? '1 : r2_sum[63:0];
    e2_c    = {2'b00, eps_sq_r};
    reach_c = {1'b0, reach_r};
    if (e2_c > reach_c) ext_c = 1'b1;
    else ext_c = r2_c > (reach_c - e2_c);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      rot_r[0][j] <= clamp_rot(-pa_r[0][j] - pb_r[0][j] + pc_r[0][j]);
      rot_r[1][j] <= clamp_rot( pa_r[1][j] - pb_r[1][j] - pc_r[1][j]);
      rot_r[2][j] <= clamp_rot(-pa_r[2][j] - pc_r[2][j]);
    end
    m4_pw_r[0] <= -m3_pws_r;
    m4_pw_r[1] <=  m3_pwc_r;
    m4_pw_r[2] <= wide_t'({5'b0, base_r}) + m3_dwv_r;
    m4_dwv_r <= m3_dwv_r;
    m4_dwh_r <= m3_dwh_r;
    m4_r2_r  <= r2_c;
    m4_ext_r <= ext_c;
    m4_par_r <= m3_par_r;
    m4_back_r <= m3_back_r;
    m4_above_r <= m3_above_r;
    m4_flag_r <= m3_flag_r;
  end

  // ---------------- M5: tool offset, status ----------------
  wide_t m5_tpp_r [0:2];
  wide_t m5_pw_r  [0:2];
  trig_t m5_rot_r [0:2][0:2];
  wide_t m5_dwv_r, m5_dwh_r;
  logic [6:0] m5_status_r;
  logic       m5_v_r;
  logic       oor_c;

  assign oor_c = m4_ext_r && (m4_r2_r > {1'b0, reach_r});

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m5_tpp_r[i] <= fmul(op_trig(rot_r[i][2]), op_len(hand_r));
      m5_pw_r[i]  <= m4_pw_r[i];
      for (int j = 0; j < 3; j++) m5_rot_r[i][j] <= rot_r[i][j];
    end
    m5_dwv_r <= m4_dwv_r;
    m5_dwh_r <= m4_dwh_r;
    m5_status_r <= {m4_par_r, oor_c, m4_ext_r, m4_above_r,
                    m4_flag_r[1], m4_flag_r[0], m4_back_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0; m1_v_r <= 1'b0; m2_v_r <= 1'b0;
      m3_v_r <= 1'b0; m4_v_r <= 1'b0; m5_v_r <= 1'b0;
    end else begin
      f_v_r  <= cv_r[CORDIC_STEPS];
      m1_v_r <= f_v_r;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
    end
  end

  // ---------------- row serializer ----------------
  fk_out_t rows_c [0:2];
  fk_out_t hold_r [0:1];
  fk_out_t out_data_r;
  logic    out_valid_r;
  logic [1:0] pend_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rows_c[i].row              = 2'(i);
      rows_c[i].rot_col0         = m5_rot_r[i][0];
      rows_c[i].rot_col1         = m5_rot_r[i][1];
      rows_c[i].rot_col2         = m5_rot_r[i][2];
      rows_c[i].tool_position    = sat32(40'(m5_tpp_r[i]) + 40'(m5_pw_r[i]));
      rows_c[i].wrist_position   = sat32(40'(m5_pw_r[i]));
      rows_c[i].wrist_vertical   = sat32(40'(m5_dwv_r));
      rows_c[i].wrist_horizontal = sat32(40'(m5_dwh_r));
      rows_c[i].status_bits      = m5_status_r;
      rows_c[i].singular         = |m5_status_r[6:3];
      rows_c[i].last             = (i == 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      if (m5_v_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= rows_c[0];
        hold_r[0]   <= rows_c[1];
        hold_r[1]   <= rows_c[2];
        pend_r      <= 2'd2;
      end else if (pend_r != 2'd0) begin
        out_valid_r <= 1'b1;
        out_data_r  <= hold_r[0];
        hold_r[0]   <= hold_r[1];
        pend_r      <= pend_r - 2'd1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    m5_v_r |-> pend_r == 2'd0) else $error("new item reached serializer mid-burst");
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy) else $error("busy window too short");
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row != 2'd0 |-> $past(out_valid)) else $error("row gap");
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.row == 2'd2))) else $error("last flag");
`endif

endmodule
`default_nettype wire
